### hdl/shuffled_lehmer_random_generator_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the shuffled Lehmer random generator
// Shared forms for the concurrent checks in the generator's modules.
// ----------------------------------------------------------------------------
`ifndef SHUFFLED_LEHMER_RANDOM_GENERATOR_MACROS_SVH
`define SHUFFLED_LEHMER_RANDOM_GENERATOR_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SLRG_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define SLRG_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hdl/slrg_pkg.sv
// ----------------------------------------------------------------------------
// Shuffled Lehmer generator package
// Constants, widths and the sequencer state type shared by the generator.
// ----------------------------------------------------------------------------
package slrg_pkg;

  localparam int STREAM_W = 2;
  localparam int VALUE_W  = 31;

  localparam int TABLE_DEPTH_DEFAULT  = 32;
  localparam int STREAM_COUNT_DEFAULT = 4;

  // Minimal standard multiplier and the Mersenne prime modulus.
  localparam int MULT_W = 15;
  localparam logic [MULT_W-1:0]  LEH_MULT = 15'd16807;
  localparam logic [VALUE_W-1:0] LEH_MOD  = 31'h7FFF_FFFF;

  // Warm-up steps run before the table starts to fill.
  localparam int WARMUP_EXTRA = 8;

  typedef enum logic [2:0] {
    S_IDLE,
    S_LOAD,
    S_WARM_ISSUE,
    S_WARM_WAIT,
    S_DRAW_ISSUE,
    S_DRAW_WAIT,
    S_TABLE_READ
  } state_t;

endpackage

### hdl/slrg_if.sv
// ----------------------------------------------------------------------------
// Shuffled Lehmer generator channels
// Request and result channels with a valid/ready handshake.
// ----------------------------------------------------------------------------
interface slrg_req_if;
  logic                          valid;
  logic                          ready;
  logic [slrg_pkg::STREAM_W-1:0] stream;
  logic                          reseed;
  logic [slrg_pkg::VALUE_W-1:0]  seed_value;

  modport source (output valid, stream, reseed, seed_value, input ready);
  modport sink   (input valid, stream, reseed, seed_value, output ready);
endinterface

interface slrg_rsp_if;
  logic                         valid;
  logic                         ready;
  logic [slrg_pkg::VALUE_W-1:0] random_value;

  modport source (output valid, random_value, input ready);
  modport sink   (input valid, random_value, output ready);
endinterface

### hdl/slrg_lehmer.sv
// ----------------------------------------------------------------------------
// Lehmer step unit
// Two-stage pipeline computing state * 16807 mod (2^31 - 1).
// ----------------------------------------------------------------------------
module slrg_lehmer (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  input  logic [slrg_pkg::VALUE_W-1:0] in_state,
  output logic                         out_valid,
  output logic [slrg_pkg::VALUE_W-1:0] out_state
);

  localparam int PROD_W = slrg_pkg::VALUE_W + slrg_pkg::MULT_W;
  localparam int VW     = slrg_pkg::VALUE_W;

  logic              prod_valid;
  logic [PROD_W-1:0] prod;
  logic [PROD_W-1:0] prod_next;
  logic [VW:0]       fold;
  logic [VW-1:0]     result_next;

  assign prod_next = PROD_W'(in_state) * PROD_W'(slrg_pkg::LEH_MULT);

  // Since 2^31 is 1 modulo the prime, the high part folds onto the low part.
  // The sum stays below twice the modulus, so one subtraction is enough.
  always_comb begin
    fold = {1'b0, prod[VW-1:0]} + (VW+1)'(prod[PROD_W-1:VW]);
    if (fold >= {1'b0, slrg_pkg::LEH_MOD}) begin
      result_next = VW'(fold - {1'b0, slrg_pkg::LEH_MOD});
    end else begin
      result_next = fold[VW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prod_valid <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      prod_valid <= in_valid;
      out_valid  <= prod_valid;
    end
  end

  always_ff @(posedge clk) begin
    prod      <= prod_next;
    out_state <= result_next;
  end

endmodule

### hdl/slrg_slot.sv
// ----------------------------------------------------------------------------
// Shuffle slot selector
// Two-stage divide of the last output by the slot width, by reciprocal.
// ----------------------------------------------------------------------------
module slrg_slot #(
  parameter int TABLE_DEPTH = slrg_pkg::TABLE_DEPTH_DEFAULT
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  input  logic [slrg_pkg::VALUE_W-1:0]   last_value,
  output logic                           out_valid,
  output logic [$clog2(TABLE_DEPTH)-1:0] slot
);

  localparam int VW = slrg_pkg::VALUE_W;
  localparam int TW = $clog2(TABLE_DEPTH);
  localparam longint unsigned SLOT_DIV =
    64'd1 + (64'(slrg_pkg::LEH_MOD) - 64'd1) / TABLE_DEPTH;
  localparam longint unsigned RECIP = (64'd1 << VW) / SLOT_DIV;
  localparam int RW = $clog2(RECIP + 1);
  localparam int QW = RW + 1;
  localparam int PW = VW + RW;
  localparam int BW = VW + QW;

  logic          q_valid;
  logic [RW-1:0] q_est;
  logic [VW-1:0] last_r;
  logic [PW-1:0] prod;
  logic [BW-1:0] bound;
  logic [QW-1:0] q_fix;
  logic [TW-1:0] slot_next;

  // The estimate is low by at most one, so one compare fixes it.
  assign prod  = PW'(last_value) * PW'(RECIP);
  assign bound = BW'(QW'(q_est) + QW'(1)) * BW'(SLOT_DIV);

  always_comb begin
    if (BW'(last_r) >= bound) begin
      q_fix = QW'(q_est) + QW'(1);
    end else begin
      q_fix = QW'(q_est);
    end
    if (q_fix >= QW'(TABLE_DEPTH)) begin
      slot_next = TW'(TABLE_DEPTH - 1);
    end else begin
      slot_next = q_fix[TW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      q_valid   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      q_valid   <= in_valid;
      out_valid <= q_valid;
    end
  end

  always_ff @(posedge clk) begin
    q_est  <= prod[PW-1:VW];
    last_r <= last_value;
    slot   <= slot_next;
  end

endmodule

### hdl/slrg_shuffle_mem.sv
// ----------------------------------------------------------------------------
// Shuffle table memory
// One write port and one registered read port.
// ----------------------------------------------------------------------------
module slrg_shuffle_mem #(
  parameter int TABLE_DEPTH = slrg_pkg::TABLE_DEPTH_DEFAULT
) (
  input  logic                           clk,
  input  logic                           wr_en,
  input  logic [$clog2(TABLE_DEPTH)-1:0] wr_addr,
  input  logic [slrg_pkg::VALUE_W-1:0]   wr_data,
  input  logic                           rd_en,
  input  logic [$clog2(TABLE_DEPTH)-1:0] rd_addr,
  output logic [slrg_pkg::VALUE_W-1:0]   rd_data
);

  logic [slrg_pkg::VALUE_W-1:0] mem [TABLE_DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Read data holds between reads.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

### hdl/shuffled_lehmer_random_generator.sv
// ----------------------------------------------------------------------------
// Shuffled Lehmer random generator
// Park-Miller streams sharing one Bays-Durham shuffle table.
// ----------------------------------------------------------------------------
// Each request names a stream and returns one shuffled random integer in
// 1..2^31-2. A plain draw passes through the two-stage modular multiplier
// and then the registered read of the shuffle table. A request with reseed
// set, and the very first request after reset, first runs TABLE_DEPTH + 8
// dependent warm-up steps through the same multiplier. The first request
// after reset always seeds, whatever its reseed bit says; a stream that is
// drawn without ever having been seeded returns unspecified values.
// Requests are taken one at a time, but a new request is accepted while the
// previous result still waits in the output register.
// ----------------------------------------------------------------------------
`include "shuffled_lehmer_random_generator_macros.svh"

module shuffled_lehmer_random_generator #(
  parameter int TABLE_DEPTH  = slrg_pkg::TABLE_DEPTH_DEFAULT,
  parameter int STREAM_COUNT = slrg_pkg::STREAM_COUNT_DEFAULT
) (
  input  logic       clk,
  input  logic       rst,
  slrg_req_if.sink   req,
  slrg_rsp_if.source rsp
);

  localparam int VW  = slrg_pkg::VALUE_W;
  localparam int TW  = $clog2(TABLE_DEPTH);
  localparam int SIW = (STREAM_COUNT > 1) ? $clog2(STREAM_COUNT) : 1;
  localparam int NW  = $clog2(TABLE_DEPTH + slrg_pkg::WARMUP_EXTRA);
  localparam int MW  = slrg_pkg::STREAM_W + 3;

  slrg_pkg::state_t state;
  slrg_pkg::state_t state_next;

  // Sequencer working registers.
  logic [SIW-1:0] idx;
  logic [VW-1:0]  cur;
  logic [NW-1:0]  step;
  logic [TW-1:0]  slot_reg;
  logic [VW-1:0]  last_output;
  logic           table_ready;
  logic           out_valid;
  logic [VW-1:0]  out_value;

  // Stream state memory.
  logic [VW-1:0]  st_mem [STREAM_COUNT];
  logic [VW-1:0]  st_rdata;
  logic           st_re;
  logic           st_we;
  logic [SIW-1:0] req_idx;

  // Lehmer unit, slot selector and table connections.
  logic           lm_in_valid;
  logic [VW-1:0]  lm_in;
  logic           lm_valid;
  logic [VW-1:0]  lm_out;
  logic           sl_in_valid;
  logic           sl_valid;
  logic [TW-1:0]  sl_slot;
  logic           tb_we;
  logic [TW-1:0]  tb_waddr;
  logic [VW-1:0]  tb_wdata;
  logic           tb_re;
  logic [VW-1:0]  tb_rdata;

  logic           accept;
  logic           seeding;
  logic           out_free;
  logic           step_last;
  logic           step_in_table;
  logic [VW-1:0]  seed_fixed;
  logic [MW-1:0]  stream_mod;

  assign accept        = req.valid && req.ready;
  assign seeding       = req.reseed || !table_ready;
  assign out_free      = !out_valid || rsp.ready;
  assign step_last     = (step == '0);
  assign step_in_table = (step < NW'(TABLE_DEPTH));

  // A seed of zero, or one equal to the modulus, would lock the generator.
  assign seed_fixed = ((req.seed_value == '0) || (req.seed_value == slrg_pkg::LEH_MOD))
                      ? VW'(1) : req.seed_value;

  // Stream number reduced modulo the stream count by repeated subtraction.
  always_comb begin
    stream_mod = MW'(req.stream);
    for (int i = 0; i < 4; i++) begin
      if (stream_mod >= MW'(STREAM_COUNT)) begin
        stream_mod = stream_mod - MW'(STREAM_COUNT);
      end
    end
    req_idx = stream_mod[SIW-1:0];
  end

  slrg_lehmer u_lehmer (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (lm_in_valid),
    .in_state  (lm_in),
    .out_valid (lm_valid),
    .out_state (lm_out)
  );

  slrg_slot #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_slot (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (sl_in_valid),
    .last_value (last_output),
    .out_valid  (sl_valid),
    .slot       (sl_slot)
  );

  slrg_shuffle_mem #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_table (
    .clk     (clk),
    .wr_en   (tb_we),
    .wr_addr (tb_waddr),
    .wr_data (tb_wdata),
    .rd_en   (tb_re),
    .rd_addr (sl_slot),
    .rd_data (tb_rdata)
  );

  // The stream memory is read when a plain request is accepted and written
  // back once the draw has advanced the state.
  always_ff @(posedge clk) begin
    if (st_we) begin
      st_mem[idx] <= lm_out;
    end
  end

  always_ff @(posedge clk) begin
    if (st_re) begin
      st_rdata <= st_mem[req_idx];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= slrg_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next  = state;
    req.ready   = 1'b0;
    st_re       = 1'b0;
    st_we       = 1'b0;
    lm_in_valid = 1'b0;
    lm_in       = cur;
    sl_in_valid = 1'b0;
    tb_we       = 1'b0;
    tb_waddr    = slot_reg;
    tb_wdata    = cur;
    tb_re       = 1'b0;
    case (state)
      slrg_pkg::S_IDLE: begin
        req.ready = 1'b1;
        if (req.valid) begin
          st_re = !seeding;
          state_next = seeding ? slrg_pkg::S_WARM_ISSUE : slrg_pkg::S_LOAD;
        end
      end
      slrg_pkg::S_LOAD: begin
        state_next = slrg_pkg::S_DRAW_ISSUE;
      end
      slrg_pkg::S_WARM_ISSUE: begin
        lm_in_valid = 1'b1;
        state_next  = slrg_pkg::S_WARM_WAIT;
      end
      slrg_pkg::S_WARM_WAIT: begin
        // Each finished step feeds straight back into the multiplier; the
        // last TABLE_DEPTH steps fill the table downward to entry zero.
        if (lm_valid) begin
          tb_we    = step_in_table;
          tb_waddr = step[TW-1:0];
          tb_wdata = lm_out;
          if (step_last) begin
            state_next = slrg_pkg::S_DRAW_ISSUE;
          end else begin
            lm_in_valid = 1'b1;
            lm_in       = lm_out;
          end
        end
      end
      slrg_pkg::S_DRAW_ISSUE: begin
        lm_in_valid = 1'b1;
        sl_in_valid = 1'b1;
        state_next  = slrg_pkg::S_DRAW_WAIT;
      end
      slrg_pkg::S_DRAW_WAIT: begin
        if (lm_valid) begin
          st_we      = 1'b1;
          tb_re      = 1'b1;
          state_next = slrg_pkg::S_TABLE_READ;
        end
      end
      slrg_pkg::S_TABLE_READ: begin
        // The chosen entry goes out and is replaced by the new stream state.
        if (out_free) begin
          tb_we      = 1'b1;
          state_next = slrg_pkg::S_IDLE;
        end
      end
      default: begin
        state_next = slrg_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      table_ready <= 1'b0;
      last_output <= '0;
      out_valid   <= 1'b0;
    end else begin
      if (state == slrg_pkg::S_WARM_WAIT && lm_valid && step_last) begin
        table_ready <= 1'b1;
        last_output <= lm_out;
      end
      // A new result replaces the one being taken in the same cycle.
      if (state == slrg_pkg::S_TABLE_READ && out_free) begin
        last_output <= tb_rdata;
        out_valid   <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      idx  <= req_idx;
      cur  <= seed_fixed;
      step <= NW'(TABLE_DEPTH + slrg_pkg::WARMUP_EXTRA - 1);
    end
    if (state == slrg_pkg::S_LOAD) begin
      cur <= st_rdata;
    end
    if (state == slrg_pkg::S_WARM_WAIT && lm_valid) begin
      cur  <= lm_out;
      step <= step - NW'(1);
    end
    if (state == slrg_pkg::S_DRAW_WAIT && lm_valid) begin
      cur      <= lm_out;
      slot_reg <= sl_slot;
    end
    if (state == slrg_pkg::S_TABLE_READ && out_free) begin
      out_value <= tb_rdata;
    end
  end

  assign rsp.valid        = out_valid;
  assign rsp.random_value = out_value;

  // The slot selector runs only beside a draw step of the multiplier.
  `SLRG_ASSERT_SAME(a_slot_with_step, clk, rst, sl_valid, lm_valid, "slot without step")
  // No result is produced before the table has been filled.
  `SLRG_ASSERT_SAME(a_out_after_fill, clk, rst, rsp.valid, table_ready, "result before fill")
  // An accepted request always starts the sequencer.
  `SLRG_ASSERT_NEXT(a_accept_busy, clk, rst, accept, state != slrg_pkg::S_IDLE,
                    "request accepted without work")

endmodule

### test/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Shuffled Lehmer generator testbench
// Sends stream requests with random bursts and gaps, stalls the result side
// on a rotating pattern, and checks every random value against a predictor.
// ----------------------------------------------------------------------------
// The predictor keeps its own copy of the four stream states, the shared
// shuffle table and the last-output word. Each request is predicted at the
// clock edge where it is accepted, and the prediction is queued. Each result
// taken from the block is compared with the oldest queued value.
//
// A draw on a stream that has never been loaded since reset would return
// unspecified values. The request driver therefore turns such a request into
// a reseed. The very first request after reset always seeds its stream, even
// with its reseed bit clear, and the directed part starts with exactly that.
// ----------------------------------------------------------------------------
module tb;

  localparam int TABLE_DEPTH  = slrg_pkg::TABLE_DEPTH_DEFAULT;
  localparam int STREAM_COUNT = slrg_pkg::STREAM_COUNT_DEFAULT;
  localparam int RANDOM_ITEMS = 900;

  localparam int VALUE_W      = slrg_pkg::VALUE_W;
  localparam int STREAM_W     = slrg_pkg::STREAM_W;
  localparam int WARMUP_EXTRA = slrg_pkg::WARMUP_EXTRA;
  localparam logic [VALUE_W-1:0]              LEH_MOD  = slrg_pkg::LEH_MOD;
  localparam logic [slrg_pkg::MULT_W-1:0]     LEH_MULT = slrg_pkg::LEH_MULT;

  // A reseed runs TABLE_DEPTH + 8 warm-up steps.
  localparam int SETTLE_CYCLES = 2 * (TABLE_DEPTH + WARMUP_EXTRA) + 40;

  // The limit covers the slowest correct run, with every request a reseed,
  // every result held through the longest receiver stall and every request
  // after the longest gap.
  localparam int unsigned CYCLE_LIMIT = 500000;

  // Width of one table slot in the output range; the index is the top bits.
  localparam int unsigned SLOT_SPAN = 1 + (32'(LEH_MOD) - 1) / TABLE_DEPTH;

  typedef enum {SINK_ALWAYS, SINK_CHOPPY, SINK_SPARSE} sink_mode_t;

  logic clk;
  logic rst;

  slrg_req_if req ();
  slrg_rsp_if rsp ();

  shuffled_lehmer_random_generator #(
    .TABLE_DEPTH  (TABLE_DEPTH),
    .STREAM_COUNT (STREAM_COUNT)
  ) DUT (
    .clk (clk),
    .rst (rst),
    .req (req),
    .rsp (rsp)
  );

  always begin
    clk = 1'b1;
    #2;
    clk = 1'b0;
    #2;
  end

  // --------------------------------------------------------------------------
  // Predictor state: a private copy of everything the block remembers.
  // --------------------------------------------------------------------------
  logic [VALUE_W-1:0] stream_copy  [STREAM_COUNT];
  logic [VALUE_W-1:0] shuffle_copy [TABLE_DEPTH];
  logic [VALUE_W-1:0] last_copy    = '0;
  bit                 table_filled = 1'b0;

  // Random values still owed by the block, oldest first.
  logic [VALUE_W-1:0] expected_values [$];

  // Streams that the stimulus has loaded since reset.
  bit stream_loaded [STREAM_COUNT];

  int          error_count = 0;
  int unsigned cycle_count = 0;

  // Sender and receiver pacing, retuned by the tests.
  int         burst_left = 0;
  int         burst_max  = 1;
  int         gap_max    = 0;
  sink_mode_t sink_mode  = SINK_ALWAYS;

  // One step of the minimal standard generator, state * 16807 mod 2^31-1.
  function automatic logic [VALUE_W-1:0] lehmer_advance(input logic [VALUE_W-1:0] s);
    logic [63:0] product;
    product = 64'(s) * 64'(LEH_MULT);
    return VALUE_W'(product % 64'(LEH_MOD));
  endfunction

  // Seeding: both 0 and the modulus itself load as 1. The warm-up runs
  // TABLE_DEPTH + 8 steps and the last TABLE_DEPTH of them fill the table
  // from the top entry down, so the final step lands in entry 0.
  function automatic void load_stream(input int idx, input logic [VALUE_W-1:0] seed);
    logic [VALUE_W-1:0] s;
    s = seed;
    if (s == '0 || s == LEH_MOD) s = VALUE_W'(1);
    for (int n = TABLE_DEPTH + WARMUP_EXTRA - 1; n >= 0; n--) begin
      s = lehmer_advance(s);
      if (n < TABLE_DEPTH) shuffle_copy[n] = s;
    end
    stream_copy[idx] = s;
    last_copy        = shuffle_copy[0];
    table_filled     = 1'b1;
  endfunction

  // Predicts the random value for one accepted request and updates the copy.
  function automatic logic [VALUE_W-1:0] predict_draw(input logic [STREAM_W-1:0] stream,
                                                      input logic reseed,
                                                      input logic [VALUE_W-1:0] seed);
    int                 idx;
    int unsigned        slot;
    logic [VALUE_W-1:0] s;
    logic [VALUE_W-1:0] drawn;
    idx = int'(stream) % STREAM_COUNT;
    if (reseed || !table_filled) load_stream(idx, seed);
    s = lehmer_advance(stream_copy[idx]);
    stream_copy[idx] = s;
    // The previous output picks the slot; the slot hands out its old value
    // and takes the fresh state in exchange.
    slot = 32'(last_copy) / SLOT_SPAN;
    if (slot >= TABLE_DEPTH) slot = TABLE_DEPTH - 1;
    drawn              = shuffle_copy[slot];
    shuffle_copy[slot] = s;
    last_copy          = drawn;
    return drawn;
  endfunction

  // --------------------------------------------------------------------------
  // Request driver. Requests go out in bursts; before each burst the valid
  // line may drop for a random gap. Valid stays high from one request to the
  // next inside a burst, so back-to-back requests are offered every cycle.
  // --------------------------------------------------------------------------
  task automatic send_request(input logic [STREAM_W-1:0] stream, input logic reseed,
                              input logic [VALUE_W-1:0] seed);
    int   gap;
    int   idx;
    logic do_reseed;
    idx       = int'(stream) % STREAM_COUNT;
    do_reseed = reseed;
    // Never draw from a stream whose state has not been written.
    if (table_filled && !stream_loaded[idx]) do_reseed = 1'b1;
    if (burst_left == 0) begin
      gap = $urandom_range(0, gap_max);
      if (gap > 0) begin
        req.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, burst_max);
    end
    burst_left--;
    req.valid      <= 1'b1;
    req.stream     <= stream;
    req.reseed     <= do_reseed;
    req.seed_value <= seed;
    @(posedge clk);
    while (!req.ready) @(posedge clk);
    // Accepted at this edge: the first request after reset seeds regardless.
    if (do_reseed || !table_filled) stream_loaded[idx] = 1'b1;
    expected_values.push_back(predict_draw(stream, do_reseed, seed));
  endtask

  // Holds off new requests until every outstanding result has come back.
  // At least one edge passes, so valid is never lowered and raised in one step.
  task automatic drain_results();
    req.valid <= 1'b0;
    burst_left = 0;
    do @(posedge clk); while (expected_values.size() != 0);
  endtask

  // --------------------------------------------------------------------------
  // Result side: ready follows a 16-bit pattern that rotates every cycle
  // between reloads, and each reload sets it according to the current mode.
  // The sparse mode loads a pattern with a single ready bit.
  // --------------------------------------------------------------------------
  logic [15:0] stall_pattern = '1;
  int          pattern_left  = 0;

  always @(posedge clk) begin
    if (pattern_left == 0) begin
      case (sink_mode)
        SINK_ALWAYS: stall_pattern <= '1;
        SINK_CHOPPY: stall_pattern <= 16'($urandom) | 16'h0101;
        default:     stall_pattern <= 16'h8000;
      endcase
      pattern_left <= 32;
    end else begin
      stall_pattern <= {stall_pattern[0], stall_pattern[15:1]};
      pattern_left  <= pattern_left - 1;
    end
    rsp.ready <= stall_pattern[0];
  end

  // Every result taken is compared with the oldest prediction.
  always @(posedge clk) begin : check_results
    logic [VALUE_W-1:0] wanted;
    if (!rst && rsp.valid && rsp.ready) begin
      if (expected_values.size() == 0) begin
        $error("random_value: unexpected result 0x%08h with no request outstanding",
               rsp.random_value);
        error_count++;
      end else begin
        wanted = expected_values.pop_front();
        if (rsp.random_value !== wanted) begin
          $error("random_value mismatch: expected 0x%08h, actual 0x%08h",
                 wanted, rsp.random_value);
          error_count++;
        end
      end
    end
  end

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // The first request after reset seeds its stream although reseed is clear.
  task automatic test_first_request_seeds();
    gap_max   = 0;
    burst_max = 4;
    sink_mode = SINK_ALWAYS;
    send_request(2'd2, 1'b0, 31'd12345);
    send_request(2'd2, 1'b0, VALUE_W'($urandom));
    send_request(2'd2, 1'b0, VALUE_W'($urandom));
  endtask

  // Seeds of zero and of the modulus both load as one; the others are the
  // smallest and largest ordinary seeds.
  task automatic test_seed_extremes();
    gap_max   = 3;
    burst_max = 2;
    sink_mode = SINK_CHOPPY;
    send_request(2'd0, 1'b1, '0);
    send_request(2'd0, 1'b0, VALUE_W'($urandom));
    send_request(2'd1, 1'b1, LEH_MOD);
    send_request(2'd1, 1'b0, VALUE_W'($urandom));
    send_request(2'd3, 1'b1, 31'd1);
    send_request(2'd3, 1'b0, VALUE_W'($urandom));
    send_request(2'd2, 1'b1, LEH_MOD - VALUE_W'(1));
    send_request(2'd2, 1'b0, VALUE_W'($urandom));
  endtask

  // All four streams loaded with alternating bit patterns, then drawn in turn
  // so that they share and disturb one shuffle table.
  task automatic test_stream_interleave();
    gap_max   = 1;
    burst_max = 6;
    sink_mode = SINK_SPARSE;
    send_request(2'd0, 1'b1, 31'h5555_5555);
    send_request(2'd1, 1'b1, 31'h2AAA_AAAA);
    send_request(2'd2, 1'b1, 31'h0F0F_0F0F);
    send_request(2'd3, 1'b1, 31'h70F0_F0F0);
    for (int k = 0; k < 8; k++) begin
      send_request(STREAM_W'(k), 1'b0, VALUE_W'($urandom));
    end
  endtask

  // Mostly plain draws on random streams with occasional reseeds. Pacing on
  // both sides is retuned every 75 requests, and three times the sender waits for
  // the block to run completely dry.
  task automatic test_random_traffic();
    logic [STREAM_W-1:0] stream;
    logic                reseed;
    logic [VALUE_W-1:0]  seed;
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if (i % 75 == 0) begin
        sink_mode = sink_mode_t'($urandom_range(0, 2));
        gap_max   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
        burst_max = $urandom_range(1, 12);
      end
      if (i % 300 == 150) drain_results();
      stream = STREAM_W'($urandom_range(0, STREAM_COUNT - 1));
      reseed = ($urandom_range(0, 99) < 8);
      case ($urandom_range(0, 19))
        0:       seed = '0;
        1:       seed = LEH_MOD;
        2:       seed = 31'd1;
        3:       seed = LEH_MOD - VALUE_W'(1);
        default: seed = VALUE_W'($urandom);
      endcase
      send_request(stream, reseed, seed);
    end
  endtask

  initial begin
    rst            <= 1'b1;
    req.valid      <= 1'b0;
    req.stream     <= '0;
    req.reseed     <= 1'b0;
    req.seed_value <= '0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    test_first_request_seeds();
    test_seed_extremes();
    test_stream_interleave();
    drain_results();
    test_random_traffic();

    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

### files.f
+incdir+hdl
hdl/slrg_pkg.sv
hdl/slrg_if.sv
hdl/slrg_lehmer.sv
hdl/slrg_slot.sv
hdl/slrg_shuffle_mem.sv
hdl/shuffled_lehmer_random_generator.sv
test/tb.sv
